// ===== hw/rtl/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// Shared types and sizing constants for the access tag table.
// ----------------------------------------------------------------------------
package att_pkg;

  // Number of entries in the tag table.
  localparam int unsigned TableDepth = 256;

  // Entry index width, and counter width that can also hold TableDepth itself.
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam int unsigned TagW     = 32;
  localparam int unsigned EntryW   = TagW + 1;  // identifier plus permission bit
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountOutW = 9;

  typedef enum logic {
    OP_PRESENT = 1'b0,
    OP_REMOVE  = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED   = 3'd0,
    ST_KNOWN   = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4
  } status_e;

  // Write port of the entry memory.
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   addr;
    logic [EntryW-1:0] data;
  } mem_wr_t;

endpackage

// ===== hw/rtl/access_tag_table_unit.sv =====
// ----------------------------------------------------------------------------
// access_tag_table_unit
// Packed tag table with per-tag permission: look up, add, and remove tags.
// ----------------------------------------------------------------------------
// Each input transaction is handled alone. A request walks the filled part of
// the entry memory from entry 0, one read issued per cycle with compares
// pipelined behind the registered read, until a match or the fill count is
// reached. A remove that hits then shifts every later entry down one place
// through the same read port and the write port, one entry per cycle. The
// single memory read port sets this pace. The next request is taken while
// the previous result still waits in the output register; a new result is
// loaded once that register is free. No clearing pass is needed after reset:
// only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module access_tag_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] tag_id_i,
  input  logic        permit_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        grant_o,
  output logic [8:0]  entry_count_o
);

  localparam int unsigned IdxW = att_pkg::IdxW;
  localparam int unsigned CntW = att_pkg::CntW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e                      state_q, state_d;
  att_pkg::op_e                op_q, op_d;
  logic [att_pkg::TagW-1:0]    id_q, id_d;
  logic                        permit_q, permit_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             rd_cnt_q, rd_cnt_d;   // next entry to read
  logic                        cmp_v_q, cmp_v_d;     // read data in flight
  logic [CntW-1:0]             cmp_idx_q, cmp_idx_d; // entry of that data
  att_pkg::status_e            res_status_q, res_status_d;
  logic                        res_grant_q, res_grant_d;

  logic                        out_valid_q, out_valid_d;
  att_pkg::status_e            out_status_q, out_status_d;
  logic                        out_grant_q, out_grant_d;
  logic [8:0]                  out_count_q, out_count_d;

  att_pkg::mem_wr_t            mem_wr;
  logic [IdxW-1:0]             mem_raddr;
  logic [att_pkg::EntryW-1:0]  mem_rdata;

  logic                        in_accept;
  logic                        hit;
  logic                        has_room;
  logic [CntW+9-1:0]           count_wide;

  att_ram #(
    .Width (att_pkg::EntryW),
    .Depth (att_pkg::TableDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.en),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Entry layout: identifier in the upper bits, permission bit in bit 0.
  assign hit      = cmp_v_q && (mem_rdata[att_pkg::EntryW-1:1] == id_q);
  assign has_room = (fill_q < CntW'(att_pkg::TableDepth));

  // Zero-extend the fill count and take its low 9 bits for the result field.
  assign count_wide = {9'b0, fill_d};

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    id_d         = id_q;
    permit_d     = permit_q;
    fill_d       = fill_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_v_d      = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_grant_d  = out_grant_q;
    out_count_d  = out_count_q;
    mem_wr.en    = 1'b0;
    mem_wr.addr  = cmp_idx_q[IdxW-1:0];
    mem_wr.data  = {id_q, permit_q};
    mem_raddr    = rd_cnt_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d     = att_pkg::op_e'(op_i);
          id_d     = tag_id_i;
          permit_d = permit_i;
          rd_cnt_d = '0;
          state_d  = S_SEARCH;
        end
      end

      S_SEARCH: begin
        priority if (hit) begin
          if (op_q == att_pkg::OP_PRESENT) begin
            // Overwrite the stored permission in place.
            mem_wr.en    = 1'b1;
            mem_wr.addr  = cmp_idx_q[IdxW-1:0];
            res_status_d = att_pkg::ST_KNOWN;
            res_grant_d  = permit_q;
            state_d      = S_FINISH;
          end else begin
            // Shift later entries down starting with the one after the match.
            rd_cnt_d = cmp_idx_q + CntW'(1);
            state_d  = S_SHIFT;
          end
        end else if (rd_cnt_q < fill_q) begin
          // Advance the scan: issue the next read, compare it next cycle.
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_cnt_q;
          rd_cnt_d  = rd_cnt_q + CntW'(1);
        end else if (!cmp_v_q) begin
          // Scan done without a match.
          res_grant_d = 1'b0;
          if (op_q == att_pkg::OP_REMOVE) begin
            res_status_d = att_pkg::ST_ABSENT;
          end else if (has_room) begin
            mem_wr.en    = 1'b1;
            mem_wr.addr  = fill_q[IdxW-1:0];
            fill_d       = fill_q + CntW'(1);
            res_status_d = att_pkg::ST_ADDED;
          end else begin
            res_status_d = att_pkg::ST_FULL;
          end
          state_d = S_FINISH;
        end else begin
          // Last compare missed: drop it and decide next cycle.
          cmp_v_d = 1'b0;
        end
      end

      S_SHIFT: begin
        if (cmp_v_q) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = cmp_idx_q[IdxW-1:0] - IdxW'(1);
          mem_wr.data = mem_rdata;
        end
        if (rd_cnt_q < fill_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_cnt_q;
          rd_cnt_d  = rd_cnt_q + CntW'(1);
        end else if (!cmp_v_q) begin
          fill_d       = fill_q - CntW'(1);
          res_status_d = att_pkg::ST_REMOVED;
          res_grant_d  = 1'b0;
          state_d      = S_FINISH;
        end
      end

      S_FINISH: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_grant_d  = res_grant_q;
          out_count_d  = count_wide[8:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    permit_q     <= permit_d;
    rd_cnt_q     <= rd_cnt_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    out_status_q <= out_status_d;
    out_grant_q  <= out_grant_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign grant_o       = out_grant_q;
  assign entry_count_o = out_count_q;

endmodule

// ===== hw/rtl/att_ram.sv =====
// ----------------------------------------------------------------------------
// att_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module att_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for access_tag_table_unit. Requests are queued up front,
// fed through a valid/stall driver with random gaps, and every result is
// checked against a software copy of the tag table, updated per accepted
// transaction.
// ----------------------------------------------------------------------------
module testbench;
  import att_pkg::*;

  localparam realtime ClkPeriod      = 12.0;
  localparam longint  TimeoutCycles  = 1_000_000;
  localparam int      TailItems      = 40;    // no idling over the last requests
  localparam int      HoldAtResult   = 40;    // start of the long receiver hold-off
  localparam int      LongHoldCycles = 600;
  localparam int      DrainCycles    = 2 * (TableDepth + 8);
  localparam int      FillOverflow   = 8;     // fresh tags offered once the table is full
  localparam int      ChurnItems     = 110;

  typedef struct {
    op_e            op;
    logic [TagW-1:0] tag;
    logic           permit;
    bit             drain;  // hold this one until every result is in
  } tag_request_t;

  typedef struct {
    status_e              status;
    logic                 grant;
    logic [CountOutW-1:0] count;
  } tag_verdict_t;

  logic clk_i  = 1'b0;
  logic rst_n  = 1'b0;

  // request side
  logic         req_valid = 1'b0;
  tag_request_t cur_req   = '{OP_PRESENT, '0, 1'b0, 1'b0};
  logic         in_stall_o;
  logic         op_w;
  logic [31:0]  tag_w;
  logic         permit_w;

  // result side
  logic         out_valid_o;
  logic [2:0]   status_o;
  logic         grant_o;
  logic [8:0]   entry_count_o;
  logic         rsp_stall;

  tag_request_t request_queue[$];
  tag_verdict_t verdict_queue[$];
  tag_verdict_t head_verdict;

  // Shadow copy of the table.
  logic [TagW-1:0] shadow_ids   [TableDepth];
  logic            shadow_perms [TableDepth];
  int              shadow_fill = 0;

  int unsigned req_count   = 0;
  int unsigned rsp_count   = 0;
  int unsigned err_count   = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  bit          hold_used   = 1'b0;
  bit          quiet       = 1'b0;
  bit          tail_phase  = 1'b0;
  int unsigned cycle_count = 0;

  assign op_w      = cur_req.op;
  assign tag_w     = cur_req.tag;
  assign permit_w  = cur_req.permit;
  assign rsp_stall = (stall_left != 0) || (hold_left != 0);

  access_tag_table_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_o    (in_stall_o),
    .op_i          (op_w),
    .tag_id_i      (tag_w),
    .permit_i      (permit_w),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (rsp_stall),
    .status_o      (status_o),
    .grant_o       (grant_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hold reset from the start, release away from the active edge.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
  end

  // Apply one request to the shadow table and return the result it must give.
  // Search from entry 0; a hit on present rewrites the permission, a hit on
  // remove closes the gap by shifting later entries down.
  function automatic tag_verdict_t update_tag_table(tag_request_t r);
    tag_verdict_t v;
    int           pos;
    pos     = -1;
    v.grant = 1'b0;
    for (int i = 0; i < shadow_fill; i++) begin
      if (pos < 0 && shadow_ids[i] == r.tag) pos = i;
    end
    if (r.op == OP_PRESENT) begin
      if (pos >= 0) begin
        shadow_perms[pos] = r.permit;
        v.status          = ST_KNOWN;
        v.grant           = r.permit;
      end else if (shadow_fill < int'(TableDepth)) begin
        shadow_ids[shadow_fill]   = r.tag;
        shadow_perms[shadow_fill] = r.permit;
        shadow_fill++;
        v.status = ST_ADDED;  // newly added tags are never granted
      end else begin
        v.status = ST_FULL;
      end
    end else if (pos >= 0) begin
      for (int i = pos; i + 1 < shadow_fill; i++) begin
        shadow_ids[i]   = shadow_ids[i + 1];
        shadow_perms[i] = shadow_perms[i + 1];
      end
      shadow_fill--;
      v.status = ST_REMOVED;
    end else begin
      v.status = ST_ABSENT;
    end
    v.count = CountOutW'(shadow_fill);
    return v;
  endfunction

  // Switch idling off for random stretches so back-to-back traffic shows up too.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[6:0] == 7'd0) quiet <= ($urandom_range(0, 3) == 0);
  end

  // Driver: predict on acceptance, then either idle or offer the next request.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      tail_phase <= (request_queue.size() <= TailItems);
      if (!(req_valid && in_stall_o)) begin
        if (req_valid) begin
          verdict_queue.push_back(update_tag_table(cur_req));
          req_count <= req_count + 1;
        end
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (request_queue.size() != 0 &&
                     !(request_queue[0].drain && (req_valid || req_count != rsp_count))) begin
          if (!quiet && !tail_phase && $urandom_range(0, 7) == 0) begin
            // open an idle burst; this cycle counts as its first
            gap_left  <= $urandom_range(0, 13);
            req_valid <= 1'b0;
          end else begin
            cur_req   <= request_queue.pop_front();
            req_valid <= 1'b1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction and
  // stall the result channel in random bursts.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else begin
      if (out_valid_o && !rsp_stall) begin
        rsp_count <= rsp_count + 1;
        if (verdict_queue.size() == 0) begin
          $error("unexpected result: status %0d grant %0d entry_count %0d",
                 status_o, grant_o, entry_count_o);
          err_count++;
        end else begin
          head_verdict = verdict_queue.pop_front();
          if (status_o !== head_verdict.status) begin
            $error("status: expected %0d, actual %0d", head_verdict.status, status_o);
            err_count++;
          end
          if (grant_o !== head_verdict.grant) begin
            $error("grant: expected %0d, actual %0d", head_verdict.grant, grant_o);
            err_count++;
          end
          if (entry_count_o !== head_verdict.count) begin
            $error("entry_count: expected %0d, actual %0d", head_verdict.count,
                   entry_count_o);
            err_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (!quiet && !tail_phase && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 14);
      end
    end
  end

  // Long hold-off on the result side: let the block fill up and stall requests.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && rsp_count == HoldAtResult) begin
      hold_left <= LongHoldCycles;
      hold_used <= 1'b1;
    end
  end

  task automatic queue_request(op_e op, logic [TagW-1:0] tag, logic permit, bit drain);
    request_queue.push_back('{op, tag, permit, drain});
  endtask

  // Build the stimulus, wait for the last result, report.
  initial begin
    logic [TagW-1:0] known_tags[$];
    logic [TagW-1:0] fresh;
    int              fresh_count;
    int              pick;
    int              kind;

    // Directed: empty table, both extreme tags, permission rewrite,
    // absent remove, shift after removing the first entry.
    queue_request(OP_REMOVE,  32'h0000_0000, 1'b0, 1'b0);
    queue_request(OP_PRESENT, 32'h0000_0000, 1'b0, 1'b0);
    queue_request(OP_PRESENT, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_request(OP_PRESENT, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_request(OP_PRESENT, 32'h0000_0000, 1'b1, 1'b0);
    queue_request(OP_PRESENT, 32'h0000_0000, 1'b0, 1'b0);
    queue_request(OP_PRESENT, 32'h8000_0001, 1'b1, 1'b0);
    queue_request(OP_REMOVE,  32'h1234_5678, 1'b1, 1'b0);
    queue_request(OP_REMOVE,  32'h0000_0000, 1'b0, 1'b0);
    queue_request(OP_PRESENT, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_request(OP_PRESENT, 32'h8000_0001, 1'b1, 1'b0);
    queue_request(OP_REMOVE,  32'h8000_0001, 1'b0, 1'b0);
    queue_request(OP_REMOVE,  32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_request(OP_REMOVE,  32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_request(OP_PRESENT, 32'h5555_5555, 1'b1, 1'b0);
    queue_request(OP_PRESENT, 32'hAAAA_AAAA, 1'b0, 1'b0);
    queue_request(OP_PRESENT, 32'h5555_5555, 1'b0, 1'b0);
    queue_request(OP_REMOVE,  32'h5555_5555, 1'b1, 1'b0);
    queue_request(OP_REMOVE,  32'hAAAA_AAAA, 1'b0, 1'b0);

    // Fill: fresh tags until the table overflows, with repeats of stored
    // tags mixed in. Wait for the directed results before starting.
    fresh_count = 0;
    while (fresh_count < int'(TableDepth) + FillOverflow) begin
      if (known_tags.size() != 0 && $urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, known_tags.size() - 1);
        queue_request(OP_PRESENT, known_tags[pick], 1'($urandom_range(0, 1)),
                      fresh_count == 0);
      end else begin
        fresh = $urandom;
        queue_request(OP_PRESENT, fresh, 1'($urandom_range(0, 1)), fresh_count == 0);
        if (fresh_count < int'(TableDepth)) known_tags.push_back(fresh);
        fresh_count++;
      end
    end

    // Churn: removes at random positions of a full table, adds of fresh tags, hits on
    // stored tags and removes of unknown tags. Start from a quiet block.
    for (int n = 0; n < ChurnItems; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 9 && known_tags.size() != 0) begin
        pick = $urandom_range(0, known_tags.size() - 1);
        queue_request(OP_REMOVE, known_tags[pick], 1'($urandom_range(0, 1)), n == 0);
        known_tags.delete(pick);
      end else if (kind < 13 || known_tags.size() == 0) begin
        fresh = $urandom;
        queue_request(OP_PRESENT, fresh, 1'($urandom_range(0, 1)), n == 0);
        known_tags.push_back(fresh);
      end else if (kind < 17) begin
        pick = $urandom_range(0, known_tags.size() - 1);
        queue_request(OP_PRESENT, known_tags[pick], 1'($urandom_range(0, 1)), n == 0);
      end else begin
        queue_request(OP_REMOVE, $urandom, 1'($urandom_range(0, 1)), n == 0);
      end
    end

    do @(negedge clk_i);
    while (request_queue.size() != 0 || req_valid || req_count != rsp_count);
    repeat (DrainCycles) @(negedge clk_i);

    if (verdict_queue.size() != 0) begin
      $error("%0d results never arrived", verdict_queue.size());
    end
    if (err_count == 0 && verdict_queue.size() == 0) begin
      $display("access_tag_table_unit: match");
    end else begin
      $display("access_tag_table_unit: mismatch");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("access_tag_table_unit: mismatch");
    $finish;
  end

endmodule
